/* sv/ipsp_pkg.sv */
// Shared types, codes and constants of the IPS patch stream parser.
package ipsp_pkg;

   // Kind of a result request.
   typedef enum logic [2:0] {
      KIND_WRITE     = 3'd0,
      KIND_FILL      = 3'd1,
      KIND_END_OK    = 3'd2,
      KIND_NOT_PATCH = 3'd3,
      KIND_TRUNCATED = 3'd4
   } kind_type;

   // Parser phase, one-hot.
   typedef enum logic [7:0] {
      PH_HEADER = 8'b0000_0001,
      PH_OFFSET = 8'b0000_0010,
      PH_SIZE   = 8'b0000_0100,
      PH_DATA   = 8'b0000_1000,
      PH_RUNCNT = 8'b0001_0000,
      PH_RUNVAL = 8'b0010_0000,
      PH_DONE   = 8'b0100_0000,
      PH_FAIL   = 8'b1000_0000
   } phase_type;

   localparam int ADDR_W   = 25;
   localparam int OFFSET_W = 24;
   localparam int COUNT_W  = 16;
   localparam int DATA_W   = 8;
   localparam int RSP_TDATA_W = 56;

   localparam logic [15:0] HDR_LEN       = 16'd5;
   localparam logic [15:0] OFFSET_BYTES  = 16'd3;
   localparam logic [15:0] SIZE_BYTES    = 16'd2;
   localparam logic [15:0] RUNCNT_BYTES  = 16'd2;
   localparam logic [OFFSET_W-1:0] END_MARK = 24'h454F46;

   typedef struct packed {
      kind_type              kind;
      logic [ADDR_W-1:0]     address;
      logic [DATA_W-1:0]     value;
      logic [COUNT_W-1:0]    fill_count;
   } rsp_type;

   // Expected character of the "PATCH" header at a given position.
   function automatic logic [7:0] hdr_char(input logic [2:0] idx);
      logic [7:0] ch;
      case (idx)
         3'd0: ch = 8'h50;
         3'd1: ch = 8'h41;
         3'd2: ch = 8'h54;
         3'd3: ch = 8'h43;
         3'd4: ch = 8'h48;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

/* sv/ips_patch_stream_parser.sv */
// Top level of the IPS patch stream parser.
//
// Usage: patch bytes enter on the req_ channel, one byte per request, with
// req_tlast marking the final byte of a patch. The block checks the "PATCH"
// header, then decodes offset/size records and emits on the rsp_ channel one
// request per literal byte (write), one per run record (fill), one for the
// "EOF" marker, and one for a bad header or a stream that ends early.
// rsp_tuser carries the kind; rsp_tdata carries address, value and count.
// Each result is registered in the output buffer before it appears on rsp_.
// Throughput: one byte per cycle while the output buffer has room; the parse
// is a single state update per byte between the phase/field registers and a
// two-entry output buffer. When the receiver stalls, the buffer absorbs one
// more result; req_tready drops only once both entries are full.
// Reset clears the parser to expect a header and empties the output buffer.
// After a byte with req_tlast the parser also returns to the header phase,
// so the next byte starts a new patch. Bytes after "EOF" or after a header
// mismatch produce nothing until the end of the stream.
module ips_patch_stream_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] patch_byte
   input  logic        req_tlast,   // last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [24:0] address, [32:25] value, [48:33] fill_count
   output logic [2:0]  rsp_tuser    // [2:0] kind
);
   import ipsp_pkg::*;

   phase_type            phase_ff, phase_in;
   logic [COUNT_W-1:0]   field_pos_ff, field_pos_in;
   logic [OFFSET_W-1:0]  offset_ff, offset_in;
   logic [COUNT_W-1:0]   size_ff, size_in;
   logic [COUNT_W-1:0]   run_ff, run_in;

   logic                 accept;
   logic                 res_valid;
   rsp_type              res;
   logic [COUNT_W-1:0]   pos_inc;
   logic [OFFSET_W-1:0]  offset_shift;
   logic [COUNT_W-1:0]   size_shift;
   logic [COUNT_W-1:0]   run_shift;
   logic                 mid_record;
   logic                 buf_ready;
   logic                 rsp_valid_w;
   rsp_type              rsp_data_w;
   logic [7:0]           b;

   assign b            = req_tdata;
   assign req_tready   = buf_ready;
   assign accept       = req_tvalid && req_tready;
   assign pos_inc      = field_pos_ff + 16'd1;
   assign offset_shift = {offset_ff[15:0], b};
   assign size_shift   = {size_ff[7:0], b};
   assign run_shift    = {run_ff[7:0], b};
   assign mid_record   = (phase_ff == PH_OFFSET) || (phase_ff == PH_SIZE) ||
                         (phase_ff == PH_DATA) || (phase_ff == PH_RUNCNT) ||
                         (phase_ff == PH_RUNVAL);

   always_comb begin
      phase_in     = phase_ff;
      field_pos_in = field_pos_ff;
      offset_in    = offset_ff;
      size_in      = size_ff;
      run_in       = run_ff;
      res_valid    = 1'b0;
      res.kind       = KIND_WRITE;
      res.address    = '0;
      res.value      = '0;
      res.fill_count = '0;

      case (phase_ff)
         PH_HEADER: begin
            if (field_pos_ff >= HDR_LEN || b != hdr_char(field_pos_ff[2:0])) begin
               res_valid = 1'b1;
               res.kind  = KIND_NOT_PATCH;
               phase_in  = PH_FAIL;
            end else begin
               field_pos_in = pos_inc;
               if (pos_inc == HDR_LEN) begin
                  field_pos_in = '0;
                  phase_in     = PH_OFFSET;
               end
            end
            // A stream that stops inside the header is not a patch; one that
            // stops right after it is a truncated patch.
            if (req_tlast && !res_valid) begin
               res_valid = 1'b1;
               res.kind  = (phase_in == PH_OFFSET) ? KIND_TRUNCATED : KIND_NOT_PATCH;
            end
         end
         PH_OFFSET: begin
            offset_in    = offset_shift;
            field_pos_in = pos_inc;
            if (pos_inc >= OFFSET_BYTES) begin
               field_pos_in = '0;
               if (offset_shift == END_MARK) begin
                  res_valid = 1'b1;
                  res.kind  = KIND_END_OK;
                  phase_in  = PH_DONE;
               end else begin
                  phase_in = PH_SIZE;
               end
            end
         end
         PH_SIZE: begin
            size_in      = size_shift;
            field_pos_in = pos_inc;
            if (pos_inc >= SIZE_BYTES) begin
               field_pos_in = '0;
               phase_in     = (size_shift == '0) ? PH_RUNCNT : PH_DATA;
            end
         end
         PH_DATA: begin
            res_valid    = 1'b1;
            res.kind     = KIND_WRITE;
            res.address  = {1'b0, offset_ff} + {9'd0, field_pos_ff};
            res.value    = b;
            field_pos_in = pos_inc;
            if (pos_inc >= size_ff) begin
               field_pos_in = '0;
               phase_in     = PH_OFFSET;
            end
         end
         PH_RUNCNT: begin
            run_in       = run_shift;
            field_pos_in = pos_inc;
            if (pos_inc >= RUNCNT_BYTES) begin
               field_pos_in = '0;
               phase_in     = PH_RUNVAL;
            end
         end
         PH_RUNVAL: begin
            res_valid      = 1'b1;
            res.kind       = KIND_FILL;
            res.address    = {1'b0, offset_ff};
            res.value      = b;
            res.fill_count = run_ff;
            phase_in       = PH_OFFSET;
         end
         default: begin
         end
      endcase

      // The final byte of a stream inside the records replaces whatever it
      // would have produced, unless it completes the end marker.
      if (req_tlast) begin
         if (mid_record && !(res_valid && res.kind == KIND_END_OK)) begin
            res_valid = 1'b1;
            res.kind  = KIND_TRUNCATED;
         end
         phase_in     = PH_HEADER;
         field_pos_in = '0;
         offset_in    = '0;
         size_in      = '0;
         run_in       = '0;
      end

      if (res.kind != KIND_WRITE && res.kind != KIND_FILL) begin
         res.address    = '0;
         res.value      = '0;
         res.fill_count = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         field_pos_ff <= '0;
         offset_ff    <= '0;
         size_ff      <= '0;
         run_ff       <= '0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         field_pos_ff <= field_pos_in;
         offset_ff    <= offset_in;
         size_ff      <= size_in;
         run_ff       <= run_in;
      end
   end

   ipsp_out_skid u_out_skid (
      .clock      (clock),
      .reset      (reset),
      .push       (accept && res_valid),
      .push_data  (res),
      .push_ready (buf_ready),
      .out_valid  (rsp_valid_w),
      .out_ready  (rsp_tready),
      .out_data   (rsp_data_w)
   );

   assign rsp_tvalid = rsp_valid_w;
   assign rsp_tuser  = rsp_data_w.kind;
   assign rsp_tdata  = {7'd0, rsp_data_w.fill_count, rsp_data_w.value, rsp_data_w.address};

`ifndef SYNTHESIS
   a_status_no_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_WRITE && rsp_tuser != KIND_FILL
      |-> rsp_tdata == '0)
      else $error("status result carries a nonzero payload");

   a_write_no_count: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_WRITE |-> rsp_tdata[48:33] == '0)
      else $error("byte write result carries a fill count");

   a_last_restarts: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> phase_ff == PH_HEADER && field_pos_ff == '0)
      else $error("parser did not return to header phase after last byte");

   a_data_size_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> size_ff != '0 && field_pos_ff < size_ff)
      else $error("literal data phase with an exhausted record size");
`endif

endmodule

/* sv/ipsp_out_skid.sv */
// Two-entry output buffer for result requests of the IPS patch parser.
module ipsp_out_skid (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ipsp_pkg::rsp_type push_data,
   output logic             push_ready,
   output logic             out_valid,
   input  logic             out_ready,
   output ipsp_pkg::rsp_type out_data
);
   import ipsp_pkg::*;

   logic    out_valid_ff, out_valid_in;
   logic    spare_valid_ff, spare_valid_in;
   rsp_type out_data_ff, out_data_in;
   rsp_type spare_data_ff, spare_data_in;
   logic    pop;

   assign pop        = out_valid_ff && out_ready;
   assign push_ready = !spare_valid_ff;
   assign out_valid  = out_valid_ff;
   assign out_data   = out_data_ff;

   always_comb begin
      out_valid_in   = out_valid_ff;
      spare_valid_in = spare_valid_ff;
      out_data_in    = out_data_ff;
      spare_data_in  = spare_data_ff;
      if (spare_valid_ff) begin
         if (pop) begin
            out_data_in    = spare_data_ff;
            spare_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_data_in  = push_data;
            out_valid_in = 1'b1;
         end else begin
            spare_data_in  = push_data;
            spare_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff   <= 1'b0;
         spare_valid_ff <= 1'b0;
      end else begin
         out_valid_ff   <= out_valid_in;
         spare_valid_ff <= spare_valid_in;
      end
      out_data_ff   <= out_data_in;
      spare_data_ff <= spare_data_in;
   end

`ifndef SYNTHESIS
   a_spare_needs_out: assert property (@(posedge clock) disable iff (reset)
      spare_valid_ff |-> out_valid_ff)
      else $error("spare entry held while output register is empty");

   a_spare_moves_up: assert property (@(posedge clock) disable iff (reset)
      spare_valid_ff && pop |=> out_valid_ff && !spare_valid_ff)
      else $error("spare entry not moved to output after a pop");

   a_spare_kept: assert property (@(posedge clock) disable iff (reset)
      spare_valid_ff && !pop |=> spare_valid_ff && $stable(spare_data_ff))
      else $error("spare entry lost while output is stalled");
`endif

endmodule

/* verif/tb.sv */
// Self-checking testbench for the IPS patch stream parser.
`timescale 1ns / 100ps

module tb;
   import ipsp_pkg::*;

   localparam logic [39:0] PATCH_TEXT = "PATCH";

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;    // [7:0] patch_byte
   logic        req_tlast;    // last
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;    // [24:0] address, [32:25] value, [48:33] fill_count
   logic [2:0]  rsp_tuser;    // [2:0] kind

   // Parser state as the testbench sees it.
   phase_type   parse_phase;
   logic [15:0] field_pos;
   logic [23:0] rec_offset;
   logic [15:0] rec_size;
   logic [15:0] run_count;

   rsp_type     pending_rsp[$];
   logic [7:0]  patch_q[$];
   int          error_count;
   int          bytes_sent;
   bit          no_idle;
   int          hold_request;
   int          hold_taken;
   int          hold_left;
   rsp_type     got_rsp;
   rsp_type     want_rsp;

   ips_patch_stream_parser u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic clear_parse_state();
      parse_phase = PH_HEADER;
      field_pos   = '0;
      rec_offset  = '0;
      rec_size    = '0;
      run_count   = '0;
   endtask

   // Advances the parser state by one accepted byte and queues the result it causes.
   task automatic parse_byte(input logic [7:0] b, input logic fin);
      phase_type   start;
      bit          has_rsp;
      rsp_type     r;
      start   = parse_phase;
      has_rsp = 0;
      r       = '0;
      case (parse_phase)
         PH_HEADER: begin
            if (field_pos >= 16'd5 || b != PATCH_TEXT[39 - 8 * field_pos[2:0] -: 8]) begin
               has_rsp     = 1;
               r.kind      = KIND_NOT_PATCH;
               parse_phase = PH_FAIL;
            end else begin
               field_pos = field_pos + 16'd1;
               if (field_pos == 16'd5) begin
                  field_pos   = '0;
                  parse_phase = PH_OFFSET;
               end
            end
            if (fin && !has_rsp) begin
               has_rsp = 1;
               r.kind  = (parse_phase == PH_OFFSET) ? KIND_TRUNCATED : KIND_NOT_PATCH;
            end
         end
         PH_OFFSET: begin
            rec_offset = {rec_offset[15:0], b};
            field_pos  = field_pos + 16'd1;
            if (field_pos >= 16'd3) begin
               field_pos = '0;
               if (rec_offset == END_MARK) begin
                  has_rsp     = 1;
                  r.kind      = KIND_END_OK;
                  parse_phase = PH_DONE;
               end else begin
                  parse_phase = PH_SIZE;
               end
            end
         end
         PH_SIZE: begin
            rec_size  = {rec_size[7:0], b};
            field_pos = field_pos + 16'd1;
            if (field_pos >= 16'd2) begin
               field_pos   = '0;
               parse_phase = (rec_size == 16'd0) ? PH_RUNCNT : PH_DATA;
            end
         end
         PH_DATA: begin
            has_rsp   = 1;
            r.kind    = KIND_WRITE;
            r.address = {1'b0, rec_offset} + {9'd0, field_pos};
            r.value   = b;
            field_pos = field_pos + 16'd1;
            if (field_pos >= rec_size) begin
               field_pos   = '0;
               parse_phase = PH_OFFSET;
            end
         end
         PH_RUNCNT: begin
            run_count = {run_count[7:0], b};
            field_pos = field_pos + 16'd1;
            if (field_pos >= 16'd2) begin
               field_pos   = '0;
               parse_phase = PH_RUNVAL;
            end
         end
         PH_RUNVAL: begin
            has_rsp      = 1;
            r.kind       = KIND_FILL;
            r.address    = {1'b0, rec_offset};
            r.value      = b;
            r.fill_count = run_count;
            parse_phase  = PH_OFFSET;
         end
         default: ;
      endcase
      if (fin) begin
         // A stream that ends inside the records is truncated unless it just closed with EOF.
         if (start != PH_HEADER && start != PH_DONE && start != PH_FAIL
             && !(has_rsp && r.kind == KIND_END_OK)) begin
            has_rsp = 1;
            r.kind  = KIND_TRUNCATED;
         end
         clear_parse_state();
      end
      if (has_rsp) begin
         if (r.kind != KIND_WRITE && r.kind != KIND_FILL) begin
            r.address    = '0;
            r.value      = '0;
            r.fill_count = '0;
         end
         pending_rsp.push_back(r);
      end
   endtask

   // Offers one byte, waits for its request to be accepted, then predicts its result.
   task automatic send_byte(input logic [7:0] b, input logic fin);
      while (!no_idle && $urandom_range(0, 99) < 23) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      parse_byte(b, fin);
      bytes_sent++;
   endtask

   task automatic send_patch();
      for (int i = 0; i < patch_q.size(); i++) send_byte(patch_q[i], i == patch_q.size() - 1);
      patch_q.delete();
   endtask

   task automatic add_header();
      for (int i = 0; i < 5; i++) patch_q.push_back(PATCH_TEXT[39 - 8 * i -: 8]);
   endtask

   task automatic add_offset(input logic [23:0] ofs);
      patch_q.push_back(ofs[23:16]);
      patch_q.push_back(ofs[15:8]);
      patch_q.push_back(ofs[7:0]);
   endtask

   // Builds a well-formed patch with random records; may add bytes after the marker.
   task automatic build_random_patch();
      int          n_rec;
      int          sel;
      int          len;
      logic [23:0] ofs;
      logic [15:0] cnt;
      add_header();
      n_rec = $urandom_range(0, 5);
      for (int k = 0; k < n_rec; k++) begin
         sel = $urandom_range(0, 99);
         if (sel < 10)      ofs = 24'hFFFFFF - 24'($urandom_range(0, 7));
         else if (sel < 20) ofs = 24'($urandom_range(0, 15));
         else               ofs = 24'($urandom);
         add_offset(ofs);
         if ($urandom_range(0, 99) < 65) begin
            len = $urandom_range(1, 8);
            patch_q.push_back(8'h00);
            patch_q.push_back(8'(len));
            for (int j = 0; j < len; j++) patch_q.push_back(8'($urandom));
         end else begin
            sel = $urandom_range(0, 9);
            if (sel == 0)      cnt = 16'h0000;
            else if (sel == 1) cnt = 16'hFFFF;
            else               cnt = 16'($urandom);
            patch_q.push_back(8'h00);
            patch_q.push_back(8'h00);
            patch_q.push_back(cnt[15:8]);
            patch_q.push_back(cnt[7:0]);
            patch_q.push_back(8'($urandom));
         end
      end
      add_offset(END_MARK);
      len = $urandom_range(0, 3);
      for (int j = 0; j < len; j++) patch_q.push_back(8'($urandom));
   endtask

   task automatic test_directed();
      // Writes at the top of the address space, a fill with zero count, a junk byte after EOF.
      add_header();
      patch_q = {patch_q, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h02, 8'hFF, 8'h00,
                 8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80,
                 8'h45, 8'h4F, 8'h46, 8'h33};
      send_patch();
      // Header mismatch on the second byte, then a byte that is ignored.
      patch_q = '{8'h50, 8'h58, 8'h11};
      send_patch();
      // Stream ends inside the header.
      patch_q = '{8'h50, 8'h41};
      send_patch();
      // Stream ends right after a complete header.
      add_header();
      send_patch();
   endtask

   // The receiver holds off while a long literal record streams in, so the input stalls.
   task automatic test_backpressure();
      add_header();
      add_offset(24'($urandom));
      patch_q.push_back(8'h01);
      patch_q.push_back(8'h01);
      for (int j = 0; j < 257; j++) patch_q.push_back(8'($urandom));
      add_offset(END_MARK);
      hold_request++;
      send_patch();
   endtask

   task automatic test_random_patches();
      int sel;
      int patches;
      patches = 0;
      while (bytes_sent < 760) begin
         // One stretch of patches runs with neither side idling.
         no_idle = (patches >= 8 && patches < 14);
         sel = $urandom_range(0, 99);
         if (sel < 70) begin
            build_random_patch();
         end else if (sel < 85) begin
            build_random_patch();
            patch_q = patch_q[0 : $urandom_range(0, patch_q.size() - 2)];
         end else if (sel < 93) begin
            add_header();
            patch_q[$urandom_range(0, 4)] = 8'($urandom);
            repeat ($urandom_range(0, 4)) patch_q.push_back(8'($urandom));
         end else begin
            repeat ($urandom_range(1, 6)) patch_q.push_back(8'($urandom));
         end
         send_patch();
         patches++;
      end
      no_idle = 0;
   endtask

   // Result checker and receiver-side ready.
   initial begin
      rsp_tready  = 1'b0;
      hold_left   = 0;
      hold_taken  = 0;
      error_count = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got_rsp.kind       = kind_type'(rsp_tuser);
            got_rsp.address    = rsp_tdata[24:0];
            got_rsp.value      = rsp_tdata[32:25];
            got_rsp.fill_count = rsp_tdata[48:33];
            if (pending_rsp.size() == 0) begin
               $display("%0t: unexpected result: kind %0d address %h value %h count %h",
                        $time, got_rsp.kind, got_rsp.address, got_rsp.value,
                        got_rsp.fill_count);
               error_count++;
            end else begin
               want_rsp = pending_rsp.pop_front();
               if (got_rsp.kind !== want_rsp.kind || got_rsp.address !== want_rsp.address
                   || got_rsp.value !== want_rsp.value
                   || got_rsp.fill_count !== want_rsp.fill_count) begin
                  $display("%0t: mismatch: expected kind %0d address %h value %h count %h",
                           $time, want_rsp.kind, want_rsp.address, want_rsp.value,
                           want_rsp.fill_count);
                  $display("%0t:           actual kind %0d address %h value %h count %h",
                           $time, got_rsp.kind, got_rsp.address, got_rsp.value,
                           got_rsp.fill_count);
                  error_count++;
               end
            end
         end
         if (hold_request != hold_taken) begin
            hold_taken = hold_request;
            hold_left  = 80;
         end
         if (hold_left > 0) begin
            rsp_tready <= 1'b0;
            hold_left--;
         end else begin
            rsp_tready <= no_idle || ($urandom_range(0, 99) >= 23);
         end
      end
   end

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tlast    = 1'b0;
      bytes_sent   = 0;
      no_idle      = 0;
      hold_request = 0;
      clear_parse_state();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_random_patches();
      req_tvalid <= 1'b0;
      while (pending_rsp.size() > 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #2400000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
